FILE: rtl/core/maie_pkg.sv
// Shared constants and types for the instruction execute core.
package maie_pkg;

   localparam int NUM_REGS  = 16;
   localparam int MEM_WORDS = 32;
   localparam int REG_AW    = $clog2(NUM_REGS);
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   // opcodes
   localparam logic [4:0] OP_NOP  = 5'd0;
   localparam logic [4:0] OP_MOVI = 5'd1;
   localparam logic [4:0] OP_MOVR = 5'd2;
   localparam logic [4:0] OP_ADDI = 5'd3;
   localparam logic [4:0] OP_ADDR = 5'd4;
   localparam logic [4:0] OP_SUBI = 5'd5;
   localparam logic [4:0] OP_SUBR = 5'd6;
   localparam logic [4:0] OP_MUL  = 5'd7;
   localparam logic [4:0] OP_DIV  = 5'd8;
   localparam logic [4:0] OP_AND  = 5'd9;
   localparam logic [4:0] OP_ORR  = 5'd10;
   localparam logic [4:0] OP_EOR  = 5'd11;
   localparam logic [4:0] OP_CMPI = 5'd12;
   localparam logic [4:0] OP_CMPR = 5'd13;
   localparam logic [4:0] OP_BEQ  = 5'd14;
   localparam logic [4:0] OP_BNE  = 5'd15;
   localparam logic [4:0] OP_B    = 5'd16;
   localparam logic [4:0] OP_LSL  = 5'd17;
   localparam logic [4:0] OP_LSR  = 5'd18;
   localparam logic [4:0] OP_LDR  = 5'd19;
   localparam logic [4:0] OP_STR  = 5'd20;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DIV0    = 3'd1;
   localparam logic [2:0] ST_BADOP   = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_HALTED  = 3'd4;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic mem_rd;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic is_load;
      logic div_done;
   } stat_type;

endpackage

FILE: rtl/core/maie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module maie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, hold data when not reading
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/maie_div.sv
// Iterative unsigned 32-bit restoring divider, one quotient bit per cycle.
module maie_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      trial   = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial[32]) begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: rtl/core/maie_ctrl.sv
// Sequencing state machine and result-valid control.
module maie_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  maie_pkg::stat_type stat,
   output maie_pkg::cmd_type  cmd
);
   import maie_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIV  = 4'b0100,
      S_LOAD = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            priority if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (stat.is_load) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_LOAD;
            end else begin
               if (out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_DIV: begin
            if (stat.div_done && out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_LOAD: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

FILE: rtl/core/maie_dpath.sv
// Datapath: register file, data memory, ALU, divider, PC, flags and result.
module maie_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  maie_pkg::cmd_type        cmd,
   output maie_pkg::stat_type       stat,
   input  logic [4:0]               req_func,
   input  logic [3:0]               req_dest_reg,
   input  logic [3:0]               req_src_a_reg,
   input  logic [3:0]               req_src_b_reg,
   input  logic signed [31:0]       req_immediate,
   input  logic signed [15:0]       req_branch_offset,
   output logic [15:0]              rsp_next_pc,
   output logic [2:0]               rsp_status,
   output logic                     rsp_reg_written,
   output logic [3:0]               rsp_written_reg,
   output logic signed [31:0]       rsp_written_value,
   output logic                     rsp_neg_flag,
   output logic                     rsp_zero_flag,
   output logic                     rsp_carry_flag,
   output logic                     rsp_overflow_flag,
   output logic                     rsp_mem_written,
   output logic [4:0]               rsp_mem_word_index,
   output logic signed [31:0]       rsp_mem_value
);
   import maie_pkg::*;

   // held item
   logic [4:0]        func_ff;
   logic [REG_AW-1:0] rd_ff, ra_ff;
   logic [31:0]       imm_ff;
   logic [15:0]       boff_ff;

   // architectural state
   logic [NUM_REGS-1:0]  reg_vld_ff, reg_vld_in;
   logic [MEM_WORDS-1:0] mem_vld_ff, mem_vld_in;
   logic [3:0]           nzcv_ff, nzcv_in;
   logic [15:0]          pc_ff, pc_in;
   logic                 halted_ff, halted_in;

   // result registers
   logic [15:0] out_pc_ff;
   logic [2:0]  out_st_ff;
   logic        out_wr_ff;
   logic [3:0]  out_wreg_ff;
   logic [31:0] out_wval_ff;
   logic [3:0]  out_nzcv_ff;
   logic        out_mw_ff;
   logic [4:0]  out_midx_ff;
   logic [31:0] out_mval_ff;

   // read side
   logic              sel_rd;
   logic [REG_AW-1:0] rdaddr_b;
   logic [REG_AW-1:0] rb_or_rd_ff;
   logic [31:0]       rdata_a, rdata_b, mem_rdata;
   logic [31:0]       va, vb, vd;

   // execute
   logic [31:0] x, y, yeff;
   logic [32:0] sum;
   logic        is_sub, v_bit;
   logic [31:0] idx;
   logic        in_range;
   logic [31:0] mag_a, mag_b, quo;
   logic        div_done;
   logic [15:0] pc_next, pc_branch;
   logic [2:0]  status;
   logic        wreg, wmem, set_flags, halt_now;
   logic [31:0] wval;
   logic [3:0]  flags_new;
   logic [3:0]  nzcv_out;

   // pick second read port: rd for compares and stores, else rb
   assign sel_rd   = (req_func == OP_CMPI) || (req_func == OP_CMPR) || (req_func == OP_STR);
   assign rdaddr_b = sel_rd ? req_dest_reg : req_src_b_reg;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= req_func;
         rd_ff       <= req_dest_reg;
         ra_ff       <= req_src_a_reg;
         imm_ff      <= req_immediate;
         boff_ff     <= req_branch_offset;
         rb_or_rd_ff <= rdaddr_b;
      end
   end

   maie_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
      .clock (clock),
      .we    (cmd.commit && wreg),
      .waddr (rd_ff),
      .wdata (wval),
      .re    (cmd.capture),
      .raddr (req_src_a_reg),
      .rdata (rdata_a)
   );

   maie_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
      .clock (clock),
      .we    (cmd.commit && wreg),
      .waddr (rd_ff),
      .wdata (wval),
      .re    (cmd.capture),
      .raddr (rdaddr_b),
      .rdata (rdata_b)
   );

   maie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
      .clock (clock),
      .we    (cmd.commit && wmem),
      .waddr (idx[MEM_AW-1:0]),
      .wdata (vd),
      .re    (cmd.mem_rd),
      .raddr (idx[MEM_AW-1:0]),
      .rdata (mem_rdata)
   );

   // never-written entries read as zero
   assign va = reg_vld_ff[ra_ff] ? rdata_a : 32'd0;
   assign vb = reg_vld_ff[rb_or_rd_ff] ? rdata_b : 32'd0;
   assign vd = vb;

   // shared add/subtract for ADD, SUB and CMP
   always_comb begin
      is_sub = (func_ff == OP_SUBI) || (func_ff == OP_SUBR) ||
               (func_ff == OP_CMPI) || (func_ff == OP_CMPR);
      x = ((func_ff == OP_CMPI) || (func_ff == OP_CMPR)) ? vd : va;
      if (func_ff == OP_CMPR) begin
         y = va;
      end else if ((func_ff == OP_ADDR) || (func_ff == OP_SUBR)) begin
         y = vb;
      end else begin
         y = imm_ff;
      end
      yeff  = is_sub ? ~y : y;
      sum   = {1'b0, x} + {1'b0, yeff} + {32'd0, is_sub};
      v_bit = ~(x[31] ^ yeff[31]) & (x[31] ^ sum[31]);
   end

   assign flags_new = {sum[31], (sum[31:0] == 32'd0), sum[32], v_bit};

   // memory index and bounds
   assign idx      = va + imm_ff;
   assign in_range = idx < 32'(MEM_WORDS);

   // signed divide on magnitudes
   assign mag_a = va[31] ? (32'd0 - va) : va;
   assign mag_b = vb[31] ? (32'd0 - vb) : vb;

   maie_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag_a),
      .divisor  (mag_b),
      .done     (div_done),
      .quotient (quo)
   );

   assign stat.is_div   = !halted_ff && (func_ff == OP_DIV) && (vb != 32'd0);
   assign stat.is_load  = !halted_ff && (func_ff == OP_LDR) && in_range;
   assign stat.div_done = div_done;

   assign pc_branch = pc_ff + boff_ff;

   // result of the held item
   always_comb begin
      pc_next   = pc_ff + 16'd1;
      status    = ST_OK;
      wreg      = 1'b0;
      wmem      = 1'b0;
      wval      = 32'd0;
      set_flags = 1'b0;
      halt_now  = 1'b0;
      if (halted_ff) begin
         status  = ST_HALTED;
         pc_next = pc_ff;
      end else begin
         unique case (func_ff)
            OP_NOP: ;
            OP_MOVI: begin wreg = 1'b1; wval = imm_ff; end
            OP_MOVR: begin wreg = 1'b1; wval = va; end
            OP_ADDI, OP_ADDR, OP_SUBI, OP_SUBR: begin
               wreg      = 1'b1;
               wval      = sum[31:0];
               set_flags = 1'b1;
            end
            OP_MUL: begin wreg = 1'b1; wval = va * vb; end
            OP_DIV: begin
               if (vb == 32'd0) begin
                  status   = ST_DIV0;
                  halt_now = 1'b1;
                  pc_next  = pc_ff;
               end else begin
                  wreg = 1'b1;
                  wval = (va[31] ^ vb[31]) ? (32'd0 - quo) : quo;
               end
            end
            OP_AND: begin wreg = 1'b1; wval = va & vb; end
            OP_ORR: begin wreg = 1'b1; wval = va | vb; end
            OP_EOR: begin wreg = 1'b1; wval = va ^ vb; end
            OP_CMPI, OP_CMPR: set_flags = 1'b1;
            OP_BEQ: if (nzcv_ff[2]) pc_next = pc_branch;
            OP_BNE: if (!nzcv_ff[2]) pc_next = pc_branch;
            OP_B: pc_next = pc_branch;
            OP_LSL: begin
               wreg = 1'b1;
               wval = (imm_ff[31:5] != 27'd0) ? 32'd0 : (va << imm_ff[4:0]);
            end
            OP_LSR: begin
               wreg = 1'b1;
               wval = (imm_ff[31:5] != 27'd0) ? 32'd0 : (va >> imm_ff[4:0]);
            end
            OP_LDR: begin
               if (in_range) begin
                  wreg = 1'b1;
                  wval = mem_vld_ff[idx[MEM_AW-1:0]] ? mem_rdata : 32'd0;
               end else begin
                  status = ST_RANGE;
               end
            end
            OP_STR: begin
               if (in_range) begin
                  wmem = 1'b1;
               end else begin
                  status = ST_RANGE;
               end
            end
            default: begin
               status   = ST_BADOP;
               halt_now = 1'b1;
               pc_next  = pc_ff;
            end
         endcase
      end
   end

   assign nzcv_out = set_flags ? flags_new : nzcv_ff;

   // update state on commit
   always_comb begin
      reg_vld_in = reg_vld_ff;
      mem_vld_in = mem_vld_ff;
      nzcv_in    = nzcv_ff;
      pc_in      = pc_ff;
      halted_in  = halted_ff;
      if (cmd.commit) begin
         if (wreg) reg_vld_in[rd_ff] = 1'b1;
         if (wmem) mem_vld_in[idx[MEM_AW-1:0]] = 1'b1;
         nzcv_in   = nzcv_out;
         pc_in     = pc_next;
         halted_in = halted_ff || halt_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
         mem_vld_ff <= '0;
         nzcv_ff    <= 4'd0;
         pc_ff      <= 16'd0;
         halted_ff  <= 1'b0;
      end else begin
         reg_vld_ff <= reg_vld_in;
         mem_vld_ff <= mem_vld_in;
         nzcv_ff    <= nzcv_in;
         pc_ff      <= pc_in;
         halted_ff  <= halted_in;
      end
   end

   // load result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_pc_ff   <= pc_next;
         out_st_ff   <= status;
         out_wr_ff   <= wreg;
         out_wreg_ff <= wreg ? rd_ff : 4'd0;
         out_wval_ff <= wreg ? wval : 32'd0;
         out_nzcv_ff <= nzcv_out;
         out_mw_ff   <= wmem;
         out_midx_ff <= wmem ? idx[4:0] : 5'd0;
         out_mval_ff <= wmem ? vd : 32'd0;
      end
   end

   assign rsp_next_pc        = out_pc_ff;
   assign rsp_status         = out_st_ff;
   assign rsp_reg_written    = out_wr_ff;
   assign rsp_written_reg    = out_wreg_ff;
   assign rsp_written_value  = out_wval_ff;
   assign rsp_neg_flag       = out_nzcv_ff[3];
   assign rsp_zero_flag      = out_nzcv_ff[2];
   assign rsp_carry_flag     = out_nzcv_ff[1];
   assign rsp_overflow_flag  = out_nzcv_ff[0];
   assign rsp_mem_written    = out_mw_ff;
   assign rsp_mem_word_index = out_midx_ff;
   assign rsp_mem_value      = out_mval_ff;
endmodule

FILE: rtl/core/mini_arm_instruction_execute_core.sv
// Top level of the ARM-like instruction execute core.
// Usage:
//   The req_ channel carries one decoded instruction per item; the rsp_
//   channel returns exactly one result item per instruction: next PC,
//   status, register write, NZCV flags and memory store.
//   Both channels: an item moves on a rising edge with valid high and
//   stall low. The core holds one instruction at a time.
// Sequence:
//   Most instructions take a register-file read step, then an execute and
//   write-back step. An in-range LDR adds a data-memory read step.
//   A DIV with a nonzero divisor waits for the radix-2 divider (32 steps).
//   The next item is accepted as soon as the previous one is committed,
//   while its result may still wait in the output register.
// Reset:
//   Synchronous, active high. Registers, data memory, flags, PC and the
//   halt bit read as zero after reset; no clearing pass is needed.
// Stall:
//   A stalled result holds its payload; a finished instruction waits for
//   the output register to free before committing.
module mini_arm_instruction_execute_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_func,
   input  logic [3:0]         req_dest_reg,
   input  logic [3:0]         req_src_a_reg,
   input  logic [3:0]         req_src_b_reg,
   input  logic signed [31:0] req_immediate,
   input  logic signed [15:0] req_branch_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_next_pc,
   output logic [2:0]         rsp_status,
   output logic               rsp_reg_written,
   output logic [3:0]         rsp_written_reg,
   output logic signed [31:0] rsp_written_value,
   output logic               rsp_neg_flag,
   output logic               rsp_zero_flag,
   output logic               rsp_carry_flag,
   output logic               rsp_overflow_flag,
   output logic               rsp_mem_written,
   output logic [4:0]         rsp_mem_word_index,
   output logic signed [31:0] rsp_mem_value
);
   import maie_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   maie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   maie_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_dest_reg       (req_dest_reg),
      .req_src_a_reg      (req_src_a_reg),
      .req_src_b_reg      (req_src_b_reg),
      .req_immediate      (req_immediate),
      .req_branch_offset  (req_branch_offset),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_status         (rsp_status),
      .rsp_reg_written    (rsp_reg_written),
      .rsp_written_reg    (rsp_written_reg),
      .rsp_written_value  (rsp_written_value),
      .rsp_neg_flag       (rsp_neg_flag),
      .rsp_zero_flag      (rsp_zero_flag),
      .rsp_carry_flag     (rsp_carry_flag),
      .rsp_overflow_flag  (rsp_overflow_flag),
      .rsp_mem_written    (rsp_mem_written),
      .rsp_mem_word_index (rsp_mem_word_index),
      .rsp_mem_value      (rsp_mem_value)
   );
endmodule
